/* rtl/core/bmpa_pkg.sv */
`default_nettype none

package bmpa_pkg;

    // Screen request codes
    localparam logic [1:0] EV_NONE         = 2'd0;
    localparam logic [1:0] EV_POWER_SCREEN = 2'd1;
    localparam logic [1:0] EV_LOCK_ON      = 2'd2;
    localparam logic [1:0] EV_LOCK_OFF     = 2'd3;

    // Click counts that trigger actions when the window closes
    localparam logic [7:0] ADJUST_EXTRA_CLICKS = 8'd1;
    localparam logic [7:0] LOCK_EXTRA_CLICKS   = 8'd4;

    // Register indexes
    localparam logic [1:0] REG_CLICK_WINDOW = 2'd0;
    localparam logic [1:0] REG_REPEAT       = 2'd1;
    localparam logic [1:0] REG_FLOOR        = 2'd2;
    localparam logic [1:0] REG_CEILING      = 2'd3;

    // Reset values
    localparam logic [7:0] CLICK_WINDOW_RESET = 8'd13;
    localparam logic [7:0] REPEAT_RESET       = 8'd6;
    localparam logic [5:0] FLOOR_RESET        = 6'd5;
    localparam logic [5:0] CEILING_RESET      = 6'd30;
    localparam logic [5:0] POWER_RESET        = 6'd5;

    typedef struct packed {
        logic button_level;
        logic smoking_screen;
        logic power_screen_shown;
    } in_item_t;

    typedef struct packed {
        logic [1:0] screen_event;
        logic [5:0] power_level;
        logic       locked;
        logic       adjust_mode;
    } out_item_t;

    // One power step: increment, wrap to floor above the ceiling
    function automatic logic [5:0] step_power(input logic [5:0] power,
                                              input logic [5:0] floor_level,
                                              input logic [5:0] ceiling_level);
        logic [6:0] sum;
        sum = {1'b0, power} + 7'd1;
        if (sum > {1'b0, ceiling_level})
            return floor_level;
        else
            return sum[5:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/bmpa_if.sv */
`default_nettype none

// Input channel: one tick of button and screen status
interface bmpa_in_if;
    logic                valid;
    logic                ready;
    bmpa_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Output channel: screen request and status after one tick
interface bmpa_out_if;
    logic                valid;
    logic                ready;
    bmpa_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/button_multiclick_power_adjust.sv */
`default_nettype none

// Button multi-click and power-adjust controller.
// in_ch carries one transaction per scheduler tick: button level (0 pressed)
// and the smoking-screen and power-screen flags. out_ch returns exactly one
// transaction per input: the screen request code, power level, lock state
// and adjust-mode state after that tick.
// The result is registered and is valid in the cycle after the input transaction.
// Throughput: one transaction per cycle while results are taken; all state
// updates for a tick are done in combinational logic feeding the state and output registers.
// When the receiver stalls, the result is held in the output register and
// in_ch.ready drops until that result is taken; it stays high while the
// output register is empty or being drained in the same cycle.
// The APB port holds click window length, repeat interval, power floor and
// power ceiling at byte addresses 0, 4, 8 and 12; pready is always high.
// Program registers only while no transaction is in flight.
// Reset (rst_n low, asynchronous) restores the configuration registers to their defaults,
// the power level to 5, clears lock and adjust mode and empties the output.
module button_multiclick_power_adjust (
    input  wire logic         clk,
    input  wire logic         rst_n,
    bmpa_in_if.sink           in_ch,
    bmpa_out_if.source        out_ch,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready
);

    // Configuration registers
    logic [7:0] click_window_reg;
    logic [7:0] repeat_reg;
    logic [5:0] floor_reg;
    logic [5:0] ceiling_reg;

    // Tick state
    logic       last_level_reg;
    logic       window_open_reg;
    logic [7:0] window_ticks_reg;
    logic [7:0] extra_clicks_reg;
    logic       lock_reg;
    logic       adjust_reg;
    logic       repeat_allowed_reg;
    logic [7:0] hold_ticks_reg;
    logic [5:0] power_reg;

    logic       last_level_next;
    logic       window_open_next;
    logic [7:0] window_ticks_next;
    logic [7:0] extra_clicks_next;
    logic       lock_next;
    logic       adjust_next;
    logic       repeat_allowed_next;
    logic [7:0] hold_ticks_next;
    logic [5:0] power_next;
    logic [1:0] event_next;

    // Output register
    logic                out_valid_reg;
    bmpa_pkg::out_item_t out_data_reg;

    logic       accept;
    logic [1:0] reg_index;
    logic       cfg_write;

    // APB access
    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (reg_index)
            bmpa_pkg::REG_CLICK_WINDOW: prdata = {24'd0, click_window_reg};
            bmpa_pkg::REG_REPEAT:       prdata = {24'd0, repeat_reg};
            bmpa_pkg::REG_FLOOR:        prdata = {26'd0, floor_reg};
            bmpa_pkg::REG_CEILING:      prdata = {26'd0, ceiling_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            click_window_reg <= bmpa_pkg::CLICK_WINDOW_RESET;
            repeat_reg       <= bmpa_pkg::REPEAT_RESET;
            floor_reg        <= bmpa_pkg::FLOOR_RESET;
            ceiling_reg      <= bmpa_pkg::CEILING_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                bmpa_pkg::REG_CLICK_WINDOW: click_window_reg <= pwdata[7:0];
                bmpa_pkg::REG_REPEAT:       repeat_reg       <= pwdata[7:0];
                bmpa_pkg::REG_FLOOR:        floor_reg        <= pwdata[5:0];
                bmpa_pkg::REG_CEILING:      ceiling_reg      <= pwdata[5:0];
                default:                    ;
            endcase
        end
    end

    // Handshake: take a tick whenever the output register is free or draining
    assign in_ch.ready  = !out_valid_reg || out_ch.ready;
    assign accept       = in_ch.valid && in_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    // Per-tick update, in the order: adjust clear, press, hold, window
    always_comb
    begin
        logic       level;
        logic       smoking;
        logic       adj0;
        logic       may_adjust;
        logic       press;
        logic [7:0] hold_inc;
        logic [7:0] win_inc;

        level   = in_ch.data.button_level;
        smoking = in_ch.data.smoking_screen;

        adj0       = in_ch.data.power_screen_shown ? adjust_reg : 1'b0;
        may_adjust = !smoking && !lock_reg && adj0;
        press      = last_level_reg && !level;

        power_next          = power_reg;
        window_open_next    = window_open_reg;
        window_ticks_next   = window_ticks_reg;
        extra_clicks_next   = extra_clicks_reg;
        repeat_allowed_next = repeat_allowed_reg;
        hold_ticks_next     = hold_ticks_reg;
        lock_next           = lock_reg;
        adjust_next         = adj0;
        event_next          = bmpa_pkg::EV_NONE;
        last_level_next     = level;

        // Press handling
        if (press)
        begin
            if (may_adjust)
                power_next = bmpa_pkg::step_power(power_reg, floor_reg, ceiling_reg);
            if (!window_open_reg)
                window_open_next = 1'b1;
            else
            begin
                extra_clicks_next = extra_clicks_reg + 8'd1;
                window_ticks_next = 8'd0;
            end
            if (!smoking)
                event_next = bmpa_pkg::EV_POWER_SCREEN;
            repeat_allowed_next = 1'b1;
        end

        // Hold auto-repeat
        hold_inc = hold_ticks_reg + 8'd1;
        if (!level)
        begin
            if (may_adjust)
            begin
                hold_ticks_next = hold_inc;
                if (hold_inc >= repeat_reg)
                begin
                    hold_ticks_next = 8'd0;
                    event_next      = bmpa_pkg::EV_POWER_SCREEN;
                    if (repeat_allowed_next)
                        power_next = bmpa_pkg::step_power(power_next, floor_reg,
                                                          ceiling_reg);
                    if (power_next == ceiling_reg)
                        repeat_allowed_next = 1'b0;
                end
            end
        end
        else
            hold_ticks_next = 8'd0;

        // Click window advance or evaluation
        win_inc = window_ticks_next + 8'd1;
        if (window_open_next)
        begin
            window_ticks_next = win_inc;
            if (win_inc >= click_window_reg)
            begin
                window_open_next  = 1'b0;
                window_ticks_next = 8'd0;
            end
        end
        else
        begin
            if (extra_clicks_next == bmpa_pkg::ADJUST_EXTRA_CLICKS)
                adjust_next = 1'b1;
            else if (extra_clicks_next >= bmpa_pkg::LOCK_EXTRA_CLICKS)
            begin
                if (!smoking && !adj0)
                begin
                    lock_next  = !lock_reg;
                    event_next = lock_reg ? bmpa_pkg::EV_LOCK_OFF
                                          : bmpa_pkg::EV_LOCK_ON;
                end
            end
            window_ticks_next = 8'd0;
            extra_clicks_next = 8'd0;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg     <= 1'b1;
            window_open_reg    <= 1'b0;
            window_ticks_reg   <= 8'd0;
            extra_clicks_reg   <= 8'd0;
            lock_reg           <= 1'b0;
            adjust_reg         <= 1'b0;
            repeat_allowed_reg <= 1'b1;
            hold_ticks_reg     <= 8'd0;
            power_reg          <= bmpa_pkg::POWER_RESET;
        end
        else if (accept)
        begin
            last_level_reg     <= last_level_next;
            window_open_reg    <= window_open_next;
            window_ticks_reg   <= window_ticks_next;
            extra_clicks_reg   <= extra_clicks_next;
            lock_reg           <= lock_next;
            adjust_reg         <= adjust_next;
            repeat_allowed_reg <= repeat_allowed_next;
            hold_ticks_reg     <= hold_ticks_next;
            power_reg          <= power_next;
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg.screen_event <= event_next;
            out_data_reg.power_level  <= power_next;
            out_data_reg.locked       <= lock_next;
            out_data_reg.adjust_mode  <= adjust_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/bmpa_checker.sv */
`default_nettype none

module bmpa_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire bmpa_pkg::out_item_t out_data
);

    // Output is empty while reset is held
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

    // An empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // Lock requests match the reported lock state and happen outside adjust mode
    a_lock_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.screen_event == bmpa_pkg::EV_LOCK_ON ||
                      out_data.screen_event == bmpa_pkg::EV_LOCK_OFF)
        |-> !out_data.adjust_mode &&
            (out_data.locked == (out_data.screen_event == bmpa_pkg::EV_LOCK_ON)))
        else $error("lock event inconsistent with status");

    // Every input transaction produces a result on the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted transaction gave no result");

endmodule

bind button_multiclick_power_adjust bmpa_checker u_bmpa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);

`default_nettype wire

/* dv/button_multiclick_power_adjust_tb.sv */
`timescale 1ns / 100ps

module button_multiclick_power_adjust_tb;

    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef struct {
        bmpa_pkg::in_item_t tick;
        int unsigned        gap;
    } tick_entry_t;

    logic         clk;
    logic         rst_n;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    bmpa_in_if  in_ch ();
    bmpa_out_if out_ch ();

    button_multiclick_power_adjust dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Ticks waiting to be driven, and status words still owed by the block
    tick_entry_t         tick_queue[$];
    bmpa_pkg::out_item_t expected_status[$];

    int unsigned in_gap_max    = 0;
    int unsigned out_stall_max = 0;
    int unsigned in_gap_left   = 0;
    int unsigned stall_left    = 0;
    int unsigned ticks_queued  = 0;
    int unsigned check_failures = 0;
    int unsigned cycle_count   = 0;

    // Register shadow
    logic [7:0] cfg_window  = bmpa_pkg::CLICK_WINDOW_RESET;
    logic [7:0] cfg_repeat  = bmpa_pkg::REPEAT_RESET;
    logic [5:0] cfg_floor   = bmpa_pkg::FLOOR_RESET;
    logic [5:0] cfg_ceiling = bmpa_pkg::CEILING_RESET;

    // Controller state as seen after the last accepted tick
    logic       s_last_level   = 1'b1;
    logic       s_window_open  = 1'b0;
    logic [7:0] s_window_ticks = 8'd0;
    logic [7:0] s_extra        = 8'd0;
    logic       s_lock         = 1'b0;
    logic       s_adjust       = 1'b0;
    logic       s_repeat_ok    = 1'b1;
    logic [7:0] s_hold         = 8'd0;
    logic [5:0] s_power        = bmpa_pkg::POWER_RESET;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Next power level: wraps to the floor once past the ceiling
    function automatic logic [5:0] bumped_power(input logic [5:0] level);
        logic [6:0] sum;
        sum = {1'b0, level} + 7'd1;
        if (sum > {1'b0, cfg_ceiling})
            return cfg_floor;
        return sum[5:0];
    endfunction

    // Advance the controller state by one tick and return its status word
    function automatic bmpa_pkg::out_item_t tick_outcome(input bmpa_pkg::in_item_t t);
        bmpa_pkg::out_item_t status;
        logic [1:0]          request;
        logic                may_step;
        request = bmpa_pkg::EV_NONE;
        if (!t.power_screen_shown)
            s_adjust = 1'b0;
        may_step = !t.smoking_screen && !s_lock && s_adjust;

        // press: falling edge of the button line
        if (s_last_level && !t.button_level)
        begin
            if (may_step)
                s_power = bumped_power(s_power);
            if (!s_window_open)
                s_window_open = 1'b1;
            else
            begin
                s_extra = s_extra + 8'd1;
                s_window_ticks = 8'd0;
            end
            if (!t.smoking_screen)
                request = bmpa_pkg::EV_POWER_SCREEN;
            s_repeat_ok = 1'b1;
        end
        s_last_level = t.button_level;

        // holding: auto-repeat
        if (!t.button_level)
        begin
            if (may_step)
            begin
                s_hold = s_hold + 8'd1;
                if (s_hold >= cfg_repeat)
                begin
                    s_hold = 8'd0;
                    request = bmpa_pkg::EV_POWER_SCREEN;
                    if (s_repeat_ok)
                        s_power = bumped_power(s_power);
                    if (s_power == cfg_ceiling)
                        s_repeat_ok = 1'b0;
                end
            end
        end
        else
            s_hold = 8'd0;

        // click window: count up, or act on the clicks once closed
        if (s_window_open)
        begin
            s_window_ticks = s_window_ticks + 8'd1;
            if (s_window_ticks >= cfg_window)
            begin
                s_window_open = 1'b0;
                s_window_ticks = 8'd0;
            end
        end
        else
        begin
            if (s_extra == bmpa_pkg::ADJUST_EXTRA_CLICKS)
                s_adjust = 1'b1;
            else if (s_extra >= bmpa_pkg::LOCK_EXTRA_CLICKS)
            begin
                if (!t.smoking_screen && !s_adjust)
                begin
                    if (!s_lock)
                    begin
                        s_lock = 1'b1;
                        request = bmpa_pkg::EV_LOCK_ON;
                    end
                    else
                    begin
                        s_lock = 1'b0;
                        request = bmpa_pkg::EV_LOCK_OFF;
                    end
                end
            end
            s_window_ticks = 8'd0;
            s_extra = 8'd0;
        end

        status.screen_event = request;
        status.power_level  = s_power;
        status.locked       = s_lock;
        status.adjust_mode  = s_adjust;
        return status;
    endfunction

    function automatic void flag_error(input string msg);
        check_failures++;
        if (check_failures <= 10)
            $display("%0t: %s", $time, msg);
    endfunction

    // Driver: one tick transaction at a time, idle gap after each
    always @(posedge clk or negedge rst_n)
    begin : drive_ticks
        tick_entry_t next_entry;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
            in_gap_left <= 0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (in_gap_left != 0)
            begin
                in_ch.valid <= 1'b0;
                in_gap_left <= in_gap_left - 1;
            end
            else if (tick_queue.size() != 0)
            begin
                next_entry = tick_queue.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.data  <= next_entry.tick;
                in_gap_left <= next_entry.gap;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Receiver: random stall after each status transaction
    always @(posedge clk or negedge rst_n)
    begin : drive_ready
        int unsigned draw;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_left   <= 0;
        end
        else if (out_ch.valid && out_ch.ready)
        begin
            draw = $urandom_range(0, out_stall_max);
            out_ch.ready <= (draw == 0);
            stall_left   <= (draw == 0) ? 0 : draw - 1;
        end
        else if (stall_left != 0)
        begin
            stall_left   <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    // Monitor: check results first, then predict for the tick taken this edge
    always @(posedge clk)
    begin : watch_status
        bmpa_pkg::out_item_t want;
        bmpa_pkg::out_item_t got;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = out_ch.data;
                if (expected_status.size() == 0)
                    flag_error($sformatf("unexpected status: event %0d power %0d lock %0b adj %0b",
                                         got.screen_event, got.power_level, got.locked,
                                         got.adjust_mode));
                else
                begin
                    want = expected_status.pop_front();
                    if (got.screen_event != want.screen_event ||
                        got.power_level != want.power_level ||
                        got.locked != want.locked ||
                        got.adjust_mode != want.adjust_mode)
                        flag_error($sformatf({"status mismatch: exp event %0d power %0d lock %0b ",
                                              "adj %0b, got event %0d power %0d lock %0b adj %0b"},
                                             want.screen_event, want.power_level, want.locked,
                                             want.adjust_mode, got.screen_event, got.power_level,
                                             got.locked, got.adjust_mode));
                end
            end
            if (in_ch.valid && in_ch.ready)
                expected_status.push_back(tick_outcome(in_ch.data));
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_tick(input logic level, input logic smoking, input logic shown);
        tick_entry_t entry;
        entry.tick.button_level       = level;
        entry.tick.smoking_screen     = smoking;
        entry.tick.power_screen_shown = shown;
        entry.gap = $urandom_range(0, in_gap_max);
        tick_queue.push_back(entry);
        ticks_queued++;
    endtask

    // n quick presses, then released long enough for the window to close
    task automatic click_train(input int n, input logic smoking, input logic shown);
        for (int i = 0; i < n; i++)
        begin
            push_tick(1'b0, smoking, shown);
            push_tick(1'b1, smoking, shown);
        end
        repeat (int'(cfg_window) + 2)
            push_tick(1'b1, smoking, shown);
    endtask

    task automatic hold_press(input int ticks, input logic smoking, input logic shown);
        repeat (ticks)
            push_tick(1'b0, smoking, shown);
        push_tick(1'b1, smoking, shown);
    endtask

    task automatic apb_write(input logic [1:0] index, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            bmpa_pkg::REG_CLICK_WINDOW: cfg_window  = value[7:0];
            bmpa_pkg::REG_REPEAT:       cfg_repeat  = value[7:0];
            bmpa_pkg::REG_FLOOR:        cfg_floor   = value[5:0];
            bmpa_pkg::REG_CEILING:      cfg_ceiling = value[5:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] window, input logic [7:0] rpt,
                              input logic [5:0] floor_level, input logic [5:0] ceiling_level);
        apb_write(bmpa_pkg::REG_CLICK_WINDOW, {24'd0, window});
        apb_write(bmpa_pkg::REG_REPEAT, {24'd0, rpt});
        apb_write(bmpa_pkg::REG_FLOOR, {26'd0, floor_level});
        apb_write(bmpa_pkg::REG_CEILING, {26'd0, ceiling_level});
    endtask

    // Wait until every queued tick is taken and every status word is back
    task automatic wait_drained;
        do
            @(posedge clk);
        while (tick_queue.size() != 0 || in_ch.valid || expected_status.size() != 0);
    endtask

    // Mostly click trains and adjust-mode holding, with some noise
    task automatic random_ticks(input int unsigned count, input bit allow_trains);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned max_hold;
        logic        smk;
        logic        shown;
        int          train_len[8] = '{1, 2, 2, 3, 4, 5, 5, 6};
        stop_at = ticks_queued + count;
        while (ticks_queued < stop_at)
        begin
            pick  = $urandom_range(0, 99);
            smk   = ($urandom_range(0, 99) < 15);
            shown = ($urandom_range(0, 99) < 92);
            max_hold = (cfg_repeat > 20) ? 20 : 3 * cfg_repeat + 3;
            if (pick < 30 && allow_trains)
                click_train(train_len[3'($urandom_range(0, 7))], smk, shown);
            else if (pick < 65)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    if (cfg_repeat <= 40 && $urandom_range(0, 9) == 0)
                        hold_press(cfg_repeat + 2, 1'b0, 1'b1);
                    else
                        hold_press($urandom_range(1, max_hold), smk, 1'b1);
                    repeat ($urandom_range(0, 2))
                        push_tick(1'b1, 1'b0, 1'b1);
                end
            end
            else if (pick < 80)
            begin
                repeat ($urandom_range(1, 16))
                    push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
            end
            else if (pick < 90)
            begin
                repeat ($urandom_range(1, 4))
                    push_tick(1'b1, smk, 1'b0);
            end
            else
                hold_press($urandom_range(1, max_hold), 1'b1, shown);
        end
    endtask

    task automatic run_phase(input logic [7:0] window, input logic [7:0] rpt,
                             input logic [5:0] floor_level, input logic [5:0] ceiling_level,
                             input int unsigned gap_max, input int unsigned stall_max,
                             input int unsigned count, input bit allow_trains);
        wait_drained();
        set_config(window, rpt, floor_level, ceiling_level);
        in_gap_max    = gap_max;
        out_stall_max = stall_max;
        random_ticks(count, allow_trains);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset settings: smoking-screen press, double press into
        // adjust mode, press and auto-repeat steps, power screen dropped
        push_tick(1'b1, 1'b0, 1'b1);
        push_tick(1'b0, 1'b1, 1'b1);
        push_tick(1'b1, 1'b1, 1'b1);
        push_tick(1'b0, 1'b0, 1'b1);
        repeat (13)
            push_tick(1'b1, 1'b0, 1'b1);
        hold_press(7, 1'b0, 1'b1);
        push_tick(1'b1, 1'b0, 1'b0);

        // Defaults again, full idling on both sides
        run_phase(bmpa_pkg::CLICK_WINDOW_RESET, bmpa_pkg::REPEAT_RESET,
                  bmpa_pkg::FLOOR_RESET, bmpa_pkg::CEILING_RESET,
                  12, 12, 150, 1'b1);
        // Window and repeat of one, widest power range
        run_phase(8'd1, 8'd1, 6'd0, 6'd63, 0, 12, 120, 1'b1);
        // Zero window and zero repeat, floor equal to ceiling at the top
        run_phase(8'd0, 8'd0, 6'd63, 6'd63, 12, 0, 100, 1'b1);
        // Floor above ceiling, no idling
        run_phase(8'd4, 8'd3, 6'd40, 6'd10, 0, 0, 100, 1'b1);

        // Click counter wraps: 258 presses leave one extra click
        wait_drained();
        set_config(8'd3, 8'd2, 6'd7, 6'd20);
        in_gap_max    = 12;
        out_stall_max = 12;
        push_tick(1'b1, 1'b0, 1'b0);
        click_train(258, 1'b0, 1'b1);
        random_ticks(60, 1'b1);

        // Longest window and repeat, zero power range
        run_phase(8'd255, 8'd255, 6'd0, 6'd0, 12, 12, 60, 1'b0);

        wait_drained();
        repeat (3) @(posedge clk);
        if (check_failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* button_multiclick_power_adjust.f */
rtl/core/bmpa_pkg.sv
rtl/core/bmpa_if.sv
rtl/core/button_multiclick_power_adjust.sv
rtl/core/bmpa_checker.sv
dv/button_multiclick_power_adjust_tb.sv
